FILE: rtl/bfa_pkg.sv
package bfa_pkg;

	localparam int NUM_W = 14;
	localparam int STAT_W = 2;
	localparam int WORD_BITS = 64;
	localparam int BIT_W = 6;

	localparam logic [NUM_W-1:0] BIU_RST = 14'd8192;
	localparam int CNT_RST_CAP = 8192;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_NONE_FREE = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD_NUMBER = 2'd2;

	localparam logic CFG_BITS_IN_USE = 1'b0;
	localparam logic CFG_INIT_FREE = 1'b1;

	typedef enum logic [3:0] {
		U_CLEAR,
		U_IDLE,
		U_DISP,
		U_SCAN,
		U_ACHK,
		U_ASET,
		U_FALLOC,
		U_FNONE,
		U_FBAD,
		U_FRD,
		U_FWR,
		U_FFREE
	} upc_t;

	typedef enum logic [1:0] {A_HOLD, A_INC, A_ZERO, A_DISP} addr_op_t;
	typedef enum logic [1:0] {W_NONE, W_ZERO, W_CLR, W_SET} wr_op_t;
	typedef enum logic [1:0] {R_ALLOC, R_NONE, R_BAD, R_FREE} res_t;
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_CLR_END,
		C_ACCEPT,
		C_DISPATCH,
		C_SCAN_END,
		C_HIT,
		C_OUT_SLOT
	} cond_t;

	typedef struct packed {
		logic in_rdy;
		addr_op_t aop;
		wr_op_t wop;
		logic cap;
		logic fin;
		res_t res;
		cond_t cond;
		upc_t t_true;
		upc_t t_false;
	} uword_t;

	typedef struct packed {
		logic accept;
		logic clr_end;
		logic scan_end;
		logic hit;
		logic out_slot;
		logic is_free;
		logic bad_num;
		logic lim_zero;
	} flags_t;

	function automatic uword_t ucode(upc_t s);
		uword_t w;
		w = '{in_rdy: 1'b0, aop: A_HOLD, wop: W_NONE, cap: 1'b0, fin: 1'b0,
			res: R_NONE, cond: C_ALWAYS, t_true: U_IDLE, t_false: U_IDLE};
		case (s)
			U_CLEAR: begin
				w.wop = W_ZERO;
				w.aop = A_INC;
				w.cond = C_CLR_END;
				w.t_true = U_IDLE;
				w.t_false = U_CLEAR;
			end
			U_IDLE: begin
				w.in_rdy = 1'b1;
				w.aop = A_ZERO;
				w.cond = C_ACCEPT;
				w.t_true = U_DISP;
				w.t_false = U_IDLE;
			end
			U_DISP: begin
				w.aop = A_DISP;
				w.cond = C_DISPATCH;
			end
			U_SCAN: begin
				w.aop = A_INC;
				w.cap = 1'b1;
				w.cond = C_SCAN_END;
				w.t_true = U_ACHK;
				w.t_false = U_SCAN;
			end
			U_ACHK: begin
				w.cond = C_HIT;
				w.t_true = U_ASET;
				w.t_false = U_FNONE;
			end
			U_ASET: begin
				w.wop = W_SET;
				w.t_true = U_FALLOC;
			end
			U_FALLOC: begin
				w.fin = 1'b1;
				w.res = R_ALLOC;
				w.cond = C_OUT_SLOT;
				w.t_true = U_IDLE;
				w.t_false = U_FALLOC;
			end
			U_FNONE: begin
				w.fin = 1'b1;
				w.res = R_NONE;
				w.cond = C_OUT_SLOT;
				w.t_true = U_IDLE;
				w.t_false = U_FNONE;
			end
			U_FBAD: begin
				w.fin = 1'b1;
				w.res = R_BAD;
				w.cond = C_OUT_SLOT;
				w.t_true = U_IDLE;
				w.t_false = U_FBAD;
			end
			U_FRD: begin
				w.t_true = U_FWR;
			end
			U_FWR: begin
				w.wop = W_CLR;
				w.t_true = U_FFREE;
			end
			U_FFREE: begin
				w.fin = 1'b1;
				w.res = R_FREE;
				w.cond = C_OUT_SLOT;
				w.t_true = U_IDLE;
				w.t_false = U_FFREE;
			end
			default: begin
				w.t_true = U_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/bfa_req_if.sv
interface bfa_req_if;
	import bfa_pkg::*;

	logic valid;
	logic ready;
	logic req_type;
	logic [NUM_W-1:0] entry_number;

	modport source(output valid, req_type, entry_number, input ready);
	modport sink(input valid, req_type, entry_number, output ready);
endinterface

FILE: rtl/bfa_rsp_if.sv
interface bfa_rsp_if;
	import bfa_pkg::*;

	logic valid;
	logic ready;
	logic [NUM_W-1:0] allocated_number;
	logic [STAT_W-1:0] status;
	logic [NUM_W-1:0] free_count;

	modport source(output valid, allocated_number, status, free_count, input ready);
	modport sink(input valid, allocated_number, status, free_count, output ready);
endinterface

FILE: rtl/bfa_cfg_if.sv
interface bfa_cfg_if;
	import bfa_pkg::*;

	logic valid;
	logic ready;
	logic index;
	logic [NUM_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/bfa_seq.sv
module bfa_seq (
	input logic clk,
	input logic arst_n,
	input bfa_pkg::flags_t flags,
	output bfa_pkg::uword_t uw,
	output bfa_pkg::upc_t upc
);
	import bfa_pkg::*;

	upc_t upc_q;
	upc_t upc_nx;
	upc_t disp_tgt;
	logic take;

	assign uw = ucode(upc_q);
	assign upc = upc_q;

	always_comb begin
		if (flags.is_free) begin
			disp_tgt = flags.bad_num ? U_FBAD : U_FRD;
		end else begin
			disp_tgt = flags.lim_zero ? U_FNONE : U_SCAN;
		end
	end

	always_comb begin
		take = 1'b1;
		upc_nx = uw.t_true;
		case (uw.cond)
			C_ALWAYS: take = 1'b1;
			C_CLR_END: take = flags.clr_end;
			C_ACCEPT: take = flags.accept;
			C_SCAN_END: take = flags.scan_end;
			C_HIT: take = flags.hit;
			C_OUT_SLOT: take = flags.out_slot;
			default: take = 1'b1;
		endcase
		if (uw.cond == C_DISPATCH) begin
			upc_nx = disp_tgt;
		end else if (!take) begin
			upc_nx = uw.t_false;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_CLEAR;
		end else begin
			upc_q <= upc_nx;
		end
	end

endmodule

FILE: rtl/bitmap_first_fit_allocator.sv
// channel  dir  handshake      item
// req      in   valid/ready    req_type, entry_number
// rsp      out  valid/ready    allocated_number, status, free_count
// cfg      in   valid/ready    index (0 bits_in_use, 1 initial_free_count), data
//
// Bitmap sits in a 64-bit-wide RAM; an allocate reads one word per cycle.
// Allocate: dispatch, row scan, hit check, bit set, finish; a miss goes on to finish.
// Free: dispatch, read, clear bit, finish. A free with a bad number, or an allocate
// with bits_in_use 0, finishes from dispatch. req is ready the cycle after a finish.
// After reset a clearing pass zeroes the RAM, one word a cycle; req is not ready until
// it ends, cfg is always ready. A new item is taken while a result waits on rsp; a
// stalled rsp holds the finishing step until the result register frees.
module bitmap_first_fit_allocator #(
	parameter int MAP_BITS = 8192
) (
	input logic clk,
	input logic arst_n,
	bfa_req_if.sink req,
	bfa_rsp_if.source rsp,
	bfa_cfg_if.sink cfg
);
	import bfa_pkg::*;

	localparam int ROWS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CNT_W = $clog2(MAP_BITS + 1);
	localparam int XW = (CNT_W > NUM_W) ? CNT_W : NUM_W;
	localparam int CNT_RST = (MAP_BITS < CNT_RST_CAP) ? MAP_BITS : CNT_RST_CAP;

	logic [WORD_BITS-1:0] mem [ROWS];

	uword_t uw;
	upc_t upc;
	flags_t flags;

	logic [NUM_W-1:0] bits_in_use_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_nx;
	logic [ROW_W-1:0] addr_q;
	logic req_q;
	logic [NUM_W-1:0] num_q;
	logic [WORD_BITS-1:0] data_s1;
	logic [ROW_W-1:0] row_s1;
	logic hit_q;
	logic [ROW_W-1:0] hit_row_q;
	logic [BIT_W-1:0] hit_pos_q;
	logic [WORD_BITS-1:0] word_q;
	logic out_valid_q;
	logic [NUM_W-1:0] alloc_num_q;
	logic [STAT_W-1:0] status_q;
	logic [NUM_W-1:0] fcount_q;

	logic [XW-1:0] map_x;
	logic [XW-1:0] biu_x;
	logic [XW-1:0] lim_x;
	logic [XW-1:0] lim_m1;
	logic [ROW_W-1:0] last_row;
	logic [BIT_W-1:0] last_pos;
	logic [XW-1:0] nm1_x;
	logic [ROW_W-1:0] free_row;
	logic [BIT_W-1:0] free_pos;
	logic [WORD_BITS-1:0] vmask;
	logic [WORD_BITS-1:0] clear_bits;
	logic [WORD_BITS-1:0] low_clear;
	logic scan_hit;
	logic [BIT_W-1:0] scan_pos;
	logic [XW-1:0] hit_idx;
	logic [ROW_W-1:0] wr_row;
	logic [WORD_BITS-1:0] wr_data;
	logic fin_go;
	logic [XW-1:0] cfg_x;
	logic [CNT_W-1:0] cfg_cnt;

	function automatic logic [BIT_W-1:0] enc_onehot(logic [WORD_BITS-1:0] oh);
		logic [BIT_W-1:0] p;
		p = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (oh[b]) begin
				p = p | BIT_W'(b);
			end
		end
		return p;
	endfunction

	bfa_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.flags(flags),
		.uw(uw),
		.upc(upc)
	);

	assign map_x = XW'(MAP_BITS);
	assign biu_x = XW'(bits_in_use_q);
	assign lim_x = (biu_x > map_x) ? map_x : biu_x;
	assign lim_m1 = lim_x - XW'(1);
	assign last_row = ROW_W'(lim_m1 >> BIT_W);
	assign last_pos = lim_m1[BIT_W-1:0];

	assign nm1_x = XW'(num_q) - XW'(1);
	assign free_row = ROW_W'(nm1_x >> BIT_W);
	assign free_pos = nm1_x[BIT_W-1:0];

	assign vmask = (row_s1 == last_row) ? ({WORD_BITS{1'b1}} >> (~last_pos))
		: {WORD_BITS{1'b1}};
	assign clear_bits = ~data_s1 & vmask;
	assign low_clear = clear_bits & (~clear_bits + WORD_BITS'(1));
	assign scan_hit = |clear_bits;
	assign scan_pos = enc_onehot(low_clear);

	assign hit_idx = (XW'(hit_row_q) << BIT_W) | XW'(hit_pos_q);

	assign cfg_x = XW'(cfg.data);
	assign cfg_cnt = CNT_W'((cfg_x > map_x) ? map_x : cfg_x);

	assign fin_go = uw.fin && (!out_valid_q || rsp.ready);

	always_comb begin
		flags.accept = req.valid;
		flags.clr_end = (addr_q == ROW_W'(ROWS - 1));
		flags.scan_end = scan_hit || (row_s1 == last_row);
		flags.hit = hit_q;
		flags.out_slot = !out_valid_q || rsp.ready;
		flags.is_free = (req_q == REQ_FREE);
		flags.bad_num = (num_q == '0) || (XW'(num_q) > lim_x);
		flags.lim_zero = (lim_x == '0);
	end

	always_comb begin
		wr_row = addr_q;
		wr_data = '0;
		case (uw.wop)
			W_ZERO: wr_data = '0;
			W_CLR: wr_data = data_s1 & ~(WORD_BITS'(1) << free_pos);
			W_SET: begin
				wr_row = hit_row_q;
				wr_data = word_q | (WORD_BITS'(1) << hit_pos_q);
			end
			default: wr_data = '0;
		endcase
	end

	always_comb begin
		cnt_nx = cnt_q;
		case (uw.res)
			R_ALLOC: cnt_nx = (cnt_q != '0) ? cnt_q - CNT_W'(1) : cnt_q;
			R_FREE: cnt_nx = (cnt_q < CNT_W'(MAP_BITS)) ? cnt_q + CNT_W'(1) : cnt_q;
			default: cnt_nx = cnt_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (uw.wop != W_NONE) begin
			mem[wr_row] <= wr_data;
		end
		data_s1 <= mem[addr_q];
		row_s1 <= addr_q;
	end

	always_ff @(posedge clk) begin
		if (req.valid && uw.in_rdy) begin
			req_q <= req.req_type;
			num_q <= req.entry_number;
		end
		if (uw.cap) begin
			hit_q <= scan_hit;
			hit_row_q <= row_s1;
			hit_pos_q <= scan_pos;
			word_q <= data_s1;
		end
		if (fin_go) begin
			alloc_num_q <= (uw.res == R_ALLOC) ? NUM_W'(hit_idx + XW'(1)) : '0;
			case (uw.res)
				R_NONE: status_q <= ST_NONE_FREE;
				R_BAD: status_q <= ST_BAD_NUMBER;
				default: status_q <= ST_OK;
			endcase
			fcount_q <= NUM_W'(cnt_nx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			bits_in_use_q <= BIU_RST;
			cnt_q <= CNT_W'(CNT_RST);
			out_valid_q <= 1'b0;
		end else begin
			case (uw.aop)
				A_INC: addr_q <= addr_q + ROW_W'(1);
				A_ZERO: addr_q <= '0;
				A_DISP: addr_q <= (req_q == REQ_FREE) ? free_row : addr_q + ROW_W'(1);
				default: addr_q <= addr_q;
			endcase
			if (cfg.valid && cfg.index == CFG_BITS_IN_USE) begin
				bits_in_use_q <= cfg.data;
			end
			if (fin_go) begin
				cnt_q <= cnt_nx;
			end else if (cfg.valid && cfg.index == CFG_INIT_FREE) begin
				cnt_q <= cfg_cnt;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req.ready = uw.in_rdy;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.allocated_number = alloc_num_q;
	assign rsp.status = status_q;
	assign rsp.free_count = fcount_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAP_BITS))
		else $error("free counter above map size");

	a_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (upc == U_DISP))
		else $error("accepted item not dispatched");

	a_set_clear_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.wop == W_SET) |-> !word_q[hit_pos_q])
		else $error("allocation targets a used entry");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> (rsp.allocated_number == '0))
		else $error("failed request returns an entry");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(uw.fin))
		else $error("result without a finishing step");

endmodule
